### hdl/assert_macros.svh
// Assertion macros used by the top level of the gap tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define NSGT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define NSGT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hdl/nsgt_pkg.sv
// Package of the neighbor gap tracker: sizes, constants, types and states.
package nsgt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    localparam int ADDR_W     = 16;
    localparam int SEQ_W      = 8;
    localparam int AVG_W      = 16;
    localparam int ALPHA_W    = 9;
    localparam int INDEX_W    = 6;
    localparam int WHOLE_W    = 8;
    localparam int HUND_W     = 7;

    localparam logic [ALPHA_W-1:0] EWMA_ONE    = 9'h100;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 9'h040;
    localparam logic [AVG_W-1:0]   AVG_INIT    = 16'h0100;
    localparam logic [AVG_W-1:0]   AVG_MAX     = 16'hFF00;
    localparam logic [HUND_W-1:0]  HUNDRED     = 7'd100;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SEQ_W-1:0]  last_seq;
        logic [AVG_W-1:0]  avg;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_ADD,
        S_OUT
    } t_state;

endpackage

### hdl/nsgt_if.sv
// Channel interfaces of the gap tracker: packet input, result output, configuration.
interface nsgt_in_if
    import nsgt_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] src_addr;
    logic [SEQ_W-1:0]  seq_num;

    modport source (output valid, output src_addr, output seq_num, input ready);
    modport sink   (input valid, input src_addr, input seq_num, output ready);
endinterface

interface nsgt_out_if
    import nsgt_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               dropped;
    logic               new_entry;
    logic [INDEX_W-1:0] entry_index;
    logic [AVG_W-1:0]   avg_gap;
    logic [WHOLE_W-1:0] gap_whole;
    logic [HUND_W-1:0]  gap_hundredths;

    modport source (output valid, output dropped, output new_entry, output entry_index,
                    output avg_gap, output gap_whole, output gap_hundredths, input ready);
    modport sink   (input valid, input dropped, input new_entry, input entry_index,
                    input avg_gap, input gap_whole, input gap_hundredths, output ready);
endinterface

interface nsgt_cfg_if
    import nsgt_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [ALPHA_W-1:0] ewma_alpha;

    modport source (output valid, output ewma_alpha, input ready);
    modport sink   (input valid, input ewma_alpha, output ready);
endinterface

### hdl/neighbor_seqno_gap_tracker_unit.sv
// Top level of the neighbor sequence-gap tracker: table scan, allocation and result output.
//
// Each input beat is one received broadcast (sender address and sequence number). The
// block keeps a table of TABLE_ENTRIES neighbors in a single synchronous RAM whose word
// holds the sender address, the last sequence number and the 8.8 average gap. A packet
// is handled one at a time: the beat is taken in S_IDLE, then a linear scan reads one
// table entry per cycle from slot 0 up to the matching slot or to the last allocated
// slot (no scan for an empty table), then the multiply/add unit runs through S_MUL and
// S_ADD, and S_OUT writes the entry back and loads the result register. A drop goes
// from the scan straight to S_OUT. The result register is separate from the input side,
// so the next beat is taken while an earlier result still waits; the block only holds
// off in the write-back cycle if that register is still occupied. An unknown sender with
// a full table yields a result beat with dropped set and all other fields zero, and
// leaves the table alone. Entries are never freed. The table needs no clearing after
// reset: only slots below the allocation count are ever read. The ewma_alpha register
// (reset 64, values above 256 act as 256) is written through the configuration channel,
// which is always ready; it should be written only while no packet is in flight.
`include "assert_macros.svh"

module neighbor_seqno_gap_tracker_unit
    import nsgt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    nsgt_in_if.sink           i_in,
    nsgt_cfg_if.sink          i_cfg,
    nsgt_out_if.source        o_out
);

    t_state             r_state, n_state;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [CNT_W-1:0]   r_used, n_used;
    logic [ADDR_W-1:0]  r_addr, n_addr;
    logic [SEQ_W-1:0]   r_seq, n_seq;
    logic [SEQ_W-1:0]   r_last, n_last;
    logic [AVG_W-1:0]   r_avg_old, n_avg_old;
    logic [IDX_W-1:0]   r_slot, n_slot;
    logic               r_fresh, n_fresh;
    logic               r_drop, n_drop;
    logic [ALPHA_W-1:0] r_alpha;

    logic               r_out_valid, n_out_valid;
    logic               r_out_drop, n_out_drop;
    logic               r_out_fresh, n_out_fresh;
    logic [INDEX_W-1:0] r_out_index, n_out_index;
    logic [AVG_W-1:0]   r_out_avg, n_out_avg;
    logic [WHOLE_W-1:0] r_out_whole, n_out_whole;
    logic [HUND_W-1:0]  r_out_hund, n_out_hund;

    logic               w_in_accept;
    logic               w_rd_en;
    logic [IDX_W-1:0]   w_rd_addr;
    logic               w_wr_en;
    t_entry             w_wr_data;
    t_entry             w_rd_entry;
    logic [SEQ_W-1:0]   w_gap;
    logic [AVG_W-1:0]   w_avg_new;
    logic               w_out_free;
    logic [14:0]        w_hund_prod;
    logic               w_last_slot;

    // Table memory: one word per neighbor.
    nsgt_ram #(
        .DATA_W ($bits(t_entry)),
        .DEPTH  (TABLE_ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_slot),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_entry)
    );

    // The wrapping gap is one for a fresh entry, since its last number is seq minus one.
    assign w_gap = r_seq - r_last;

    nsgt_ewma u_ewma (
        .i_clk   (i_clk),
        .i_gap   (w_gap),
        .i_avg   (r_avg_old),
        .i_alpha (r_alpha),
        .o_avg   (w_avg_new)
    );

    assign w_in_accept = i_in.valid && i_in.ready;
    assign w_out_free  = !r_out_valid || o_out.ready;
    assign w_last_slot = ((CNT_W'(r_idx) + 1'b1) == r_used);

    // Hundredths depend only on the fraction byte: floor(100 * frac / 256) is below 100.
    assign w_hund_prod = 15'(w_avg_new[7:0]) * 15'(HUNDRED);

    assign w_wr_data.addr     = r_addr;
    assign w_wr_data.last_seq = r_seq;
    assign w_wr_data.avg      = w_avg_new;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_used      = r_used;
        n_addr      = r_addr;
        n_seq       = r_seq;
        n_last      = r_last;
        n_avg_old   = r_avg_old;
        n_slot      = r_slot;
        n_fresh     = r_fresh;
        n_drop      = r_drop;
        n_out_drop  = r_out_drop;
        n_out_fresh = r_out_fresh;
        n_out_index = r_out_index;
        n_out_avg   = r_out_avg;
        n_out_whole = r_out_whole;
        n_out_hund  = r_out_hund;
        n_out_valid = r_out_valid && !o_out.ready;
        i_in.ready  = 1'b0;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_idx;
        w_wr_en     = 1'b0;

        case (r_state)
            S_IDLE: begin
                // Ready is high throughout this state, so a valid beat is taken here.
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_addr  = i_in.src_addr;
                    n_seq   = i_in.seq_num;
                    n_idx   = '0;
                    n_drop  = 1'b0;
                    n_fresh = 1'b0;
                    if (r_used != '0) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = '0;
                        n_state   = S_SCAN;
                    end else begin
                        // Empty table: the sender takes slot zero right away.
                        n_slot    = '0;
                        n_fresh   = 1'b1;
                        n_last    = i_in.seq_num - 1'b1;
                        n_avg_old = AVG_INIT;
                        n_state   = S_MUL;
                    end
                end
            end
            S_SCAN: begin
                // The RAM output holds the entry at r_idx, read in the previous cycle.
                if (w_rd_entry.addr == r_addr) begin
                    n_slot    = r_idx;
                    n_last    = w_rd_entry.last_seq;
                    n_avg_old = w_rd_entry.avg;
                    n_state   = S_MUL;
                end else if (w_last_slot) begin
                    if (r_used == CNT_W'(TABLE_ENTRIES)) begin
                        n_drop  = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        n_slot    = IDX_W'(r_used);
                        n_fresh   = 1'b1;
                        n_last    = r_seq - 1'b1;
                        n_avg_old = AVG_INIT;
                        n_state   = S_MUL;
                    end
                end else begin
                    n_idx     = r_idx + 1'b1;
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_idx + 1'b1;
                end
            end
            S_MUL: begin
                n_state = S_ADD;
            end
            S_ADD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_drop  = r_drop;
                    if (r_drop) begin
                        n_out_fresh = 1'b0;
                        n_out_index = '0;
                        n_out_avg   = '0;
                        n_out_whole = '0;
                        n_out_hund  = '0;
                    end else begin
                        w_wr_en     = 1'b1;
                        n_out_fresh = r_fresh;
                        n_out_index = INDEX_W'(r_slot);
                        n_out_avg   = w_avg_new;
                        n_out_whole = w_avg_new[15:8];
                        n_out_hund  = w_hund_prod[14:8];
                        if (r_fresh) begin
                            n_used = r_used + 1'b1;
                        end
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_addr      <= n_addr;
        r_seq       <= n_seq;
        r_last      <= n_last;
        r_avg_old   <= n_avg_old;
        r_slot      <= n_slot;
        r_fresh     <= n_fresh;
        r_drop      <= n_drop;
        r_out_drop  <= n_out_drop;
        r_out_fresh <= n_out_fresh;
        r_out_index <= n_out_index;
        r_out_avg   <= n_out_avg;
        r_out_whole <= n_out_whole;
        r_out_hund  <= n_out_hund;
    end

    // Configuration: the weight register is always ready to take a beat.
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha <= ALPHA_RESET;
        end else if (i_cfg.valid) begin
            r_alpha <= i_cfg.ewma_alpha;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.dropped        = r_out_drop;
    assign o_out.new_entry      = r_out_fresh;
    assign o_out.entry_index    = r_out_index;
    assign o_out.avg_gap        = r_out_avg;
    assign o_out.gap_whole      = r_out_whole;
    assign o_out.gap_hundredths = r_out_hund;

    `NSGT_ASSERT_NOW(a_used_bound, 1'b1, r_used <= CNT_W'(TABLE_ENTRIES), "allocation count overflow")
    `NSGT_ASSERT_NOW(a_drop_zero, o_out.valid && o_out.dropped, !o_out.new_entry && o_out.avg_gap == '0 && o_out.entry_index == '0, "dropped result carries data")
    `NSGT_ASSERT_NOW(a_wr_only_out, w_wr_en, r_state == S_OUT && !r_drop, "table written outside write-back")
    `NSGT_ASSERT_NEXT(a_accept_busy, w_in_accept, r_state != S_IDLE, "input beat taken but block stayed idle")
    `NSGT_ASSERT_NOW(a_drop_full, r_state == S_OUT && r_drop, r_used == CNT_W'(TABLE_ENTRIES), "drop with free slots")

endmodule

### hdl/nsgt_ram.sv
// Simple dual-port synchronous RAM with a registered read port.
module nsgt_ram #(
    parameter int DATA_W = 40,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [DATA_W-1:0] i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [DATA_W-1:0] o_rd_data
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hdl/nsgt_ewma.sv
// Two-stage moving-average update: products, then sum with saturation.
module nsgt_ewma
    import nsgt_pkg::*;
(
    input  logic               i_clk,
    input  logic [SEQ_W-1:0]   i_gap,
    input  logic [AVG_W-1:0]   i_avg,
    input  logic [ALPHA_W-1:0] i_alpha,
    output logic [AVG_W-1:0]   o_avg
);

    localparam int P1_W  = SEQ_W + ALPHA_W;
    localparam int P2_W  = AVG_W + ALPHA_W;
    localparam int SUM_W = P2_W - 8 + 1;

    logic [ALPHA_W-1:0] w_alpha_sat;
    logic [ALPHA_W-1:0] w_alpha_rest;
    logic [P1_W-1:0]    r_p1;
    logic [P2_W-1:0]    r_p2;
    logic [SUM_W-1:0]   w_sum;
    logic [AVG_W-1:0]   r_avg;

    // Weights above one are treated as exactly one.
    assign w_alpha_sat  = (i_alpha > EWMA_ONE) ? EWMA_ONE : i_alpha;
    assign w_alpha_rest = EWMA_ONE - w_alpha_sat;

    always_ff @(posedge i_clk) begin
        r_p1 <= P1_W'(i_gap) * P1_W'(w_alpha_sat);
        r_p2 <= P2_W'(i_avg) * P2_W'(w_alpha_rest);
    end

    assign w_sum = SUM_W'(r_p1) + SUM_W'(r_p2[P2_W-1:8]);

    always_ff @(posedge i_clk) begin
        r_avg <= (w_sum > SUM_W'(AVG_MAX)) ? AVG_MAX : w_sum[AVG_W-1:0];
    end

    assign o_avg = r_avg;

endmodule
